### hdl/plint_pkg.sv
// ---------------------------------------------------------------------------
// plint_pkg
// Shared types and constants for the piecewise linear interpolator.
// ---------------------------------------------------------------------------
`default_nettype none

package plint_pkg;

	localparam int MAX_POINTS_DEF = 64;

	// Field and register widths fixed by the interface.
	localparam int DATA_W  = 32;
	localparam int INDEX_W = 6;
	localparam int COUNT_W = 7;
	localparam int PADDR_W = 3;

	// Register index of point_count (byte address 4 * index).
	localparam logic REG_POINT_COUNT = 1'b0;

	// Item operation codes.
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_LAST,
		ST_RD_FIRST,
		ST_SCAN,
		ST_MUL,
		ST_DIV,
		ST_FIX,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

### hdl/plint_ram.sv
// ---------------------------------------------------------------------------
// plint_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module plint_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### hdl/piecewise_linear_interpolator_top.sv
// A load transaction is written into the table as it is accepted.
// One item at a time, set by the table scan over the RAM read port and the 32-step divider.
// Reset clears point_count and the control state; the table is not cleared.
// ---------------------------------------------------------------------------
// piecewise_linear_interpolator_top
// Breakpoint table with a sequenced search, multiply and iterative divide.
// ---------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_interpolator_top
	import plint_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  wire                       clk,
	input  wire                       arst_n,
	// APB configuration port
	input  wire                       psel,
	input  wire                       penable,
	input  wire                       pwrite,
	input  wire         [PADDR_W-1:0] paddr,
	input  wire         [31:0]        pwdata,
	output logic        [31:0]        prdata,
	output logic                      pready,
	// Input channel
	input  wire                       in_valid,
	output logic                      in_stall,
	input  wire                       op,
	input  wire         [INDEX_W-1:0] point_index,
	input  wire  signed [DATA_W-1:0]  x_value,
	input  wire  signed [DATA_W-1:0]  y_value,
	// Output channel
	output logic                      out_valid,
	input  wire                       out_stall,
	output logic signed [DATA_W-1:0]  y_out
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);

	state_t state_q, state_d;

	logic [COUNT_W-1:0] point_count_q;
	logic               out_valid_q;
	logic               in_accept;
	logic               out_free;

	logic [CW-1:0]      n_val, n_q;
	logic [AW-1:0]      seg_q;
	logic [AW-1:0]      raddr;
	logic               we;
	logic [2*DATA_W-1:0] rdata;
	logic signed [DATA_W-1:0] rd_x, rd_y;

	logic signed [DATA_W-1:0] x_q, xa_q, ya_q, xb_q, yb_q, yl_q, res_q;
	logic [DATA_W-1:0]  den_q, rem_q, quo_q;
	logic               neg_q;
	logic [4:0]         cnt_q;

	logic [DATA_W-1:0]  run, rise;
	logic [2*DATA_W-1:0] prod;
	logic [DATA_W:0]    trial, diff;

	// Configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == REG_POINT_COUNT) begin
			point_count_q <= pwdata[COUNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_POINT_COUNT) begin
			prdata = {{(32 - COUNT_W){1'b0}}, point_count_q};
		end
	end

	// Handshakes
	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	// A count above capacity is used as the capacity.
	assign n_val = ({{(32 - COUNT_W){1'b0}}, point_count_q} > 32'(MAX_POINTS)) ?
		CW'(MAX_POINTS) : CW'(point_count_q);

	// Breakpoint table: x in the upper half of each word, y in the lower.
	assign we = in_accept && op == OP_LOAD &&
		{{(32 - INDEX_W){1'b0}}, point_index} < 32'(MAX_POINTS);

	plint_ram #(
		.WIDTH(2 * DATA_W),
		.DEPTH(MAX_POINTS)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (AW'(point_index)),
		.wdata ({x_value, y_value}),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd_x = $signed(rdata[2*DATA_W-1:DATA_W]);
	assign rd_y = $signed(rdata[DATA_W-1:0]);

	// Inside a segment both differences are below 2^32, so 32-bit wrap is exact.
	assign run  = DATA_W'(x_q - xa_q);
	assign rise = (yb_q < ya_q) ? DATA_W'(ya_q - yb_q) : DATA_W'(yb_q - ya_q);
	assign prod = {{DATA_W{1'b0}}, run} * {{DATA_W{1'b0}}, rise};

	// The remainder stays below the divisor, so one 33-bit subtract per step.
	assign trial = {rem_q, quo_q[DATA_W-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		raddr   = seg_q;
		unique case (state_q)
			ST_IDLE: begin
				raddr = AW'(n_val - CW'(1));
				if (in_accept && op == OP_QUERY) begin
					state_d = (n_val < CW'(2)) ? ST_DONE : ST_RD_LAST;
				end
			end
			ST_RD_LAST: begin
				raddr = '0;
				state_d = (x_q > rd_x) ? ST_DONE : ST_RD_FIRST;
			end
			ST_RD_FIRST: begin
				raddr = AW'(1);
				state_d = (x_q < rd_x) ? ST_DONE : ST_SCAN;
			end
			ST_SCAN: begin
				raddr = seg_q + AW'(1);
				if (x_q >= xa_q && x_q <= rd_x) begin
					state_d = ST_MUL;
				end else if (CW'(seg_q) + CW'(1) == n_q) begin
					state_d = ST_DONE;
				end
			end
			ST_MUL: begin
				state_d = (x_q <= xa_q || x_q >= xb_q) ? ST_DONE : ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == 5'd31) begin
					state_d = ST_FIX;
				end
			end
			ST_FIX: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q   <= x_value;
				n_q   <= n_val;
				res_q <= x_value;
			end
			ST_RD_LAST: begin
				yl_q  <= rd_y;
				res_q <= rd_y;
			end
			ST_RD_FIRST: begin
				res_q <= rd_y;
				xa_q  <= rd_x;
				ya_q  <= rd_y;
				seg_q <= AW'(1);
			end
			ST_SCAN: begin
				res_q <= yl_q;
				if (x_q >= xa_q && x_q <= rd_x) begin
					xb_q <= rd_x;
					yb_q <= rd_y;
				end else begin
					xa_q  <= rd_x;
					ya_q  <= rd_y;
					seg_q <= seg_q + AW'(1);
				end
			end
			ST_MUL: begin
				res_q <= (x_q <= xa_q) ? ya_q : yb_q;
				// The quotient fits 32 bits, so the high product half starts the remainder.
				rem_q <= prod[2*DATA_W-1:DATA_W];
				quo_q <= prod[DATA_W-1:0];
				den_q <= DATA_W'(xb_q - xa_q);
				neg_q <= (yb_q < ya_q);
				cnt_q <= '0;
			end
			ST_DIV: begin
				cnt_q <= cnt_q + 5'd1;
				if (!diff[DATA_W]) begin
					rem_q <= diff[DATA_W-1:0];
					quo_q <= {quo_q[DATA_W-2:0], 1'b1};
				end else begin
					rem_q <= trial[DATA_W-1:0];
					quo_q <= {quo_q[DATA_W-2:0], 1'b0};
				end
			end
			ST_FIX: begin
				res_q <= neg_q ? ya_q - $signed(quo_q) : ya_q + $signed(quo_q);
			end
			ST_DONE: begin
				if (out_free) begin
					y_out <= res_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

### verif/tb_piecewise_linear_interpolator_top.sv
// ---------------------------------------------------------------------------
// tb_piecewise_linear_interpolator_top
// Self-checking bench for the breakpoint table interpolator. A directed table
// covers pass-through, saturation, the breakpoint ends, zero-width and
// unsorted segments, and the 32-bit extremes. Randomized phases follow. Each
// phase programs point_count over APB, loads the table and issues queries.
// Every query transaction is checked against its row's value or an in-bench model.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_piecewise_linear_interpolator_top;
	import plint_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD     = 10;
	localparam int TOTAL_ITEMS    = 1400;
	localparam int SETTLE_CYCLES  = 150;
	localparam int TAIL_CYCLES    = 200;
	localparam int LONG_HOLD      = 600;
	localparam int WATCHDOG_LIMIT = 3000;

	localparam logic signed [DATA_W-1:0] X_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] X_MAX = 32'sh7FFF_FFFF;
	localparam logic [PADDR_W-1:0] COUNT_ADDR = PADDR_W'(4 * REG_POINT_COUNT);

	typedef enum logic [1:0] {
		ROW_LOAD,
		ROW_QUERY,
		ROW_COUNT
	} row_kind_t;

	typedef struct packed {
		row_kind_t                kind;
		logic [INDEX_W-1:0]       idx;
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] y;
		logic                     known;
		logic signed [DATA_W-1:0] want;
	} dir_row_t;

	logic                       clk;
	logic                       arst_n;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [PADDR_W-1:0]         paddr;
	logic [31:0]                pwdata;
	logic [31:0]                prdata;
	logic                       pready;
	logic                       in_valid;
	logic                       in_stall;
	logic                       op;
	logic [INDEX_W-1:0]         point_index;
	logic signed [DATA_W-1:0]   x_value;
	logic signed [DATA_W-1:0]   y_value;
	logic                       out_valid;
	logic                       out_stall;
	logic signed [DATA_W-1:0]   y_out;

	// Shadow copy of the breakpoint table and the programmed count.
	logic signed [DATA_W-1:0]   bp_x [MAX_POINTS_DEF];
	logic signed [DATA_W-1:0]   bp_y [MAX_POINTS_DEF];
	logic [COUNT_W-1:0]         table_count;

	logic signed [DATA_W-1:0]   expected_y [$];
	int                         err_count;
	int                         items_sent;
	int                         gap_mode;
	bit                         hold_request;
	int                         quiet_cycles;

	piecewise_linear_interpolator_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.point_index (point_index),
		.x_value     (x_value),
		.y_value     (y_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.y_out       (y_out)
	);

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	// Mode 0 never idles, mode 1 idles uniformly, mode 2 idles now and then.
	function automatic int draw_gap_cycles();
		if (gap_mode == 0)
			return 0;
		if (gap_mode == 1)
			return $urandom_range(0, 16);
		return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
	endfunction

	function automatic logic signed [DATA_W-1:0] predict_y(input logic signed [DATA_W-1:0] xq);
		int unsigned         n;
		longint              x, xa, xb, ya, yb;
		longint unsigned     run, rise, span, q;
		bit                  falling;
		n = (table_count > MAX_POINTS_DEF) ? MAX_POINTS_DEF : table_count;
		x = xq;
		if (n < 2)
			return xq;
		if (x > longint'(bp_x[n-1]))
			return bp_y[n-1];
		if (x < longint'(bp_x[0]))
			return bp_y[0];
		for (int s = 0; s + 1 < n; s++) begin
			xa = bp_x[s];
			xb = bp_x[s+1];
			ya = bp_y[s];
			yb = bp_y[s+1];
			if (x >= xa && x <= xb) begin
				// The segment ends are exact, so a zero-width segment never divides.
				if (x <= xa)
					return bp_y[s];
				if (x >= xb)
					return bp_y[s+1];
				run = x - xa;
				falling = (yb < ya);
				rise = falling ? ya - yb : yb - ya;
				span = xb - xa;
				q = (run * rise) / span;
				return falling ? DATA_W'(ya - longint'(q)) : DATA_W'(ya + longint'(q));
			end
		end
		return bp_y[n-1];
	endfunction

	task automatic issue_item(input logic o, input logic [INDEX_W-1:0] idx,
			input logic signed [DATA_W-1:0] x, input logic signed [DATA_W-1:0] y,
			input logic known, input logic signed [DATA_W-1:0] want);
		int gap;
		gap = draw_gap_cycles();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		op          <= o;
		point_index <= idx;
		x_value     <= x;
		y_value     <= y;
		do @(posedge clk); while (in_stall);
		if (o == OP_LOAD) begin
			bp_x[idx] = x;
			bp_y[idx] = y;
		end else begin
			expected_y.push_back(known ? want : predict_y(x));
		end
		items_sent++;
	endtask

	// Stop feeding, let every outstanding query complete, then let the block go quiet.
	task automatic settle_block();
		in_valid <= 1'b0;
		while (expected_y.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [31:0] wdata, output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= COUNT_ADDR;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_point_count(input logic [COUNT_W-1:0] cnt);
		logic [31:0] rd;
		settle_block();
		apb_access(1'b1, 32'(cnt), rd);
		apb_access(1'b0, 32'd0, rd);
		if (rd !== 32'(cnt)) begin
			err_count++;
			$display("%0t: point_count readback mismatch, expected %0d, got %0d",
				$time, cnt, rd);
		end
		table_count = cnt;
	endtask

	initial begin : stimulus
		dir_row_t                  rows [$];
		int                        count, n, nq, pick;
		bit                        full_scale, sorted, hold_done;
		longint                    xacc, lo, hi, step_max;
		logic signed [DATA_W-1:0]  xv, yv;

		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		in_valid     = 1'b0;
		op           = OP_LOAD;
		point_index  = '0;
		x_value      = '0;
		y_value      = '0;
		out_stall    = 1'b0;
		table_count  = '0;
		err_count    = 0;
		items_sent   = 0;
		gap_mode     = 1;
		hold_request = 1'b0;
		hold_done    = 1'b0;

		// After reset the count is zero, so queries pass x through.
		rows.push_back('{ROW_QUERY, 6'd0, X_MIN, 32'sd0, 1'b1, X_MIN});
		rows.push_back('{ROW_QUERY, 6'd0, X_MAX, 32'sd0, 1'b1, X_MAX});
		rows.push_back('{ROW_LOAD, 6'd0, -32'sd1000, 32'sd500, 1'b0, 32'sd0});
		rows.push_back('{ROW_LOAD, 6'd1, 32'sd0, -32'sd500, 1'b0, 32'sd0});
		rows.push_back('{ROW_LOAD, 6'd2, 32'sd0, 32'sd700, 1'b0, 32'sd0});
		rows.push_back('{ROW_LOAD, 6'd3, 32'sd1000, 32'sd1000, 1'b0, 32'sd0});
		rows.push_back('{ROW_COUNT, 6'd0, 32'sd1, 32'sd0, 1'b0, 32'sd0});
		rows.push_back('{ROW_QUERY, 6'd0, 32'sd12345, 32'sd0, 1'b1, 32'sd12345});
		rows.push_back('{ROW_COUNT, 6'd0, 32'sd4, 32'sd0, 1'b0, 32'sd0});
		rows.push_back('{ROW_QUERY, 6'd0, -32'sd2000, 32'sd0, 1'b1, 32'sd500});
		rows.push_back('{ROW_QUERY, 6'd0, 32'sd2000, 32'sd0, 1'b1, 32'sd1000});
		rows.push_back('{ROW_QUERY, 6'd0, -32'sd1000, 32'sd0, 1'b1, 32'sd500});
		rows.push_back('{ROW_QUERY, 6'd0, 32'sd0, 32'sd0, 1'b1, -32'sd500});
		rows.push_back('{ROW_QUERY, 6'd0, -32'sd500, 32'sd0, 1'b0, 32'sd0});
		rows.push_back('{ROW_QUERY, 6'd0, 32'sd500, 32'sd0, 1'b0, 32'sd0});
		rows.push_back('{ROW_QUERY, 6'd0, 32'sd999, 32'sd0, 1'b0, 32'sd0});
		// Full-range segment: the product needs all 64 bits.
		rows.push_back('{ROW_LOAD, 6'd0, X_MIN, X_MAX, 1'b0, 32'sd0});
		rows.push_back('{ROW_LOAD, 6'd1, X_MAX, X_MIN, 1'b0, 32'sd0});
		rows.push_back('{ROW_COUNT, 6'd0, 32'sd2, 32'sd0, 1'b0, 32'sd0});
		rows.push_back('{ROW_QUERY, 6'd0, X_MIN, 32'sd0, 1'b1, X_MAX});
		rows.push_back('{ROW_QUERY, 6'd0, X_MAX, 32'sd0, 1'b1, X_MIN});
		rows.push_back('{ROW_QUERY, 6'd0, 32'sd0, 32'sd0, 1'b0, 32'sd0});
		rows.push_back('{ROW_QUERY, 6'd0, -32'sd1, 32'sd0, 1'b0, 32'sd0});
		// Unsorted table: the last x lies below the middle ones.
		rows.push_back('{ROW_LOAD, 6'd2, 32'sd500, 32'sd7, 1'b0, 32'sd0});
		rows.push_back('{ROW_LOAD, 6'd3, -32'sd500, -32'sd9, 1'b0, 32'sd0});
		rows.push_back('{ROW_COUNT, 6'd0, 32'sd4, 32'sd0, 1'b0, 32'sd0});
		rows.push_back('{ROW_QUERY, 6'd0, 32'sd100, 32'sd0, 1'b0, 32'sd0});
		rows.push_back('{ROW_QUERY, 6'd0, -32'sd600, 32'sd0, 1'b0, 32'sd0});
		rows.push_back('{ROW_LOAD, 6'd63, -32'sd1, -32'sd1, 1'b0, 32'sd0});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			case (rows[i].kind)
				ROW_COUNT: program_point_count(rows[i].x[COUNT_W-1:0]);
				ROW_LOAD: begin
					issue_item(OP_LOAD, rows[i].idx, rows[i].x, rows[i].y, 1'b0, 32'sd0);
				end
				default: begin
					issue_item(OP_QUERY, rows[i].idx, rows[i].x, rows[i].y,
						rows[i].known, rows[i].want);
				end
			endcase
		end

		while (items_sent < TOTAL_ITEMS) begin
			pick = $urandom_range(0, 19);
			if (pick == 0)
				count = $urandom_range(0, 1);
			else if (pick == 1)
				count = $urandom_range(64, 127);
			else
				count = $urandom_range(2, 9);
			program_point_count(COUNT_W'(count));
			n = (count > MAX_POINTS_DEF) ? MAX_POINTS_DEF : count;
			gap_mode = $urandom_range(0, 2);
			full_scale = $urandom_range(0, 1);
			sorted = ($urandom_range(0, 5) != 0);

			// Nondecreasing x that stays inside the signed 32-bit range.
			if (full_scale) begin
				step_max = (64'hFFFF_FFFF - 1000) / ((n > 1) ? n - 1 : 1);
				xacc = -64'sd2147483648 + longint'($urandom_range(0, 1000));
			end else begin
				step_max = 50;
				xacc = longint'($urandom_range(0, 2000)) - 1000;
			end

			for (int i = 0; i < n; i++) begin
				if (sorted)
					xv = DATA_W'(xacc);
				else
					xv = full_scale ? $urandom : $urandom_range(0, 2000) - 1000;
				yv = full_scale ? $urandom : $urandom_range(0, 2000) - 1000;
				issue_item(OP_LOAD, INDEX_W'(i), xv, yv, 1'b0, 32'sd0);
				if ($urandom_range(0, 7) != 0)
					xacc += longint'($urandom_range(0, 32'(step_max)));
			end

			lo = bp_x[0];
			hi = (n > 0) ? bp_x[n-1] : bp_x[0];
			if (hi < lo) begin
				xacc = lo;
				lo = hi;
				hi = xacc;
			end

			nq = $urandom_range(10, 40);
			for (int k = 0; k < nq; k++) begin
				// The hold starts at the head of a query run, so items keep coming during it.
				if (!hold_done && k == 0 && items_sent >= TOTAL_ITEMS / 2) begin
					hold_request = 1'b1;
					hold_done = 1'b1;
				end
				pick = $urandom_range(0, 99);
				if (pick < 12) begin
					issue_item(OP_LOAD, INDEX_W'($urandom), $urandom, $urandom, 1'b0, 32'sd0);
				end else begin
					if (pick < 22 || n < 2)
						xv = $urandom;
					else if (pick < 27)
						xv = $urandom_range(0, 1) ? X_MAX : X_MIN;
					else if (pick < 40)
						xv = bp_x[$urandom_range(0, n - 1)];
					else
						xv = DATA_W'(lo + longint'($urandom_range(0, 32'(hi - lo))));
					issue_item(OP_QUERY, INDEX_W'($urandom), xv, $urandom, 1'b0, 32'sd0);
				end
			end
		end

		in_valid <= 1'b0;
		while (expected_y.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0 && expected_y.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Result side: random back-pressure, one long hold when requested.
	initial begin : result_sink
		int                        gap;
		logic signed [DATA_W-1:0]  want;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				gap = LONG_HOLD;
				hold_request = 1'b0;
			end else begin
				gap = draw_gap_cycles();
			end
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			if (expected_y.size() == 0) begin
				err_count++;
				$display("%0t: unexpected transaction, expected none, got y_out %0d",
					$time, y_out);
			end else begin
				want = expected_y.pop_front();
				if (y_out !== want) begin
					err_count++;
					$display("%0t: y_out mismatch, expected %0d, got %0d",
						$time, want, y_out);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial quiet_cycles = 0;

endmodule

`default_nettype wire
